// File: rtl/tca_pkg.sv
// Package for the traffic class accounting engine.
// Holds operation and register codes, fixed field widths and shared types.
// No dependencies.
package tca_pkg;

	localparam int DEF_RULES   = 16;
	localparam int DEF_CLASSES = 16;

	localparam int OPCODE_W      = 2;
	localparam int SLOT_W        = 4;
	localparam int ADDR_W        = 32;
	localparam int CSEL_W        = 8;
	localparam int SIZE_W        = 17;
	localparam int CLASS_OUT_W   = 4;
	localparam int MARK_W        = 32;
	localparam int BYTE_W        = 64;
	localparam int PKT_W         = 32;
	localparam int RULE_COUNT_W  = 5;
	localparam int MARK_BASE_W   = 16;
	localparam int CID_W         = 32;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [OPCODE_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ACCOUNT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_RULE_COUNT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MARK_BASE    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONTAINER_ID = 2'd2;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} cnt_ctrl_t;

endpackage

// File: rtl/tca_rules.sv
// Rule table of the traffic class accounting engine: address, mask and class per slot.
// Compares all rules against a packet address and picks the highest matching slot in use.
// Depends on tca_pkg.
module tca_rules #(
	parameter int RULES   = tca_pkg::DEF_RULES,
	parameter int CLASSES = tca_pkg::DEF_CLASSES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [tca_pkg::SLOT_W-1:0]             wr_slot,
	input  logic [tca_pkg::ADDR_W-1:0]             wr_addr,
	input  logic [tca_pkg::ADDR_W-1:0]             wr_mask,
	input  logic [tca_pkg::CSEL_W-1:0]             wr_class,
	input  logic                                   cmp_en,
	input  logic [tca_pkg::ADDR_W-1:0]             pkt_addr,
	input  logic [tca_pkg::RULE_COUNT_W-1:0]       rule_count,
	output logic [$clog2(CLASSES)-1:0]             hit_class
);
	import tca_pkg::*;

	localparam int RIW = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CW  = $clog2(CLASSES);

	logic [ADDR_W-1:0] addr_tab_q  [RULES];
	logic [ADDR_W-1:0] mask_tab_q  [RULES];
	logic [CW-1:0]     class_tab_q [RULES];
	logic [RULES-1:0]  hit_now;
	logic [RULES-1:0]  hit_s1;
	logic [RIW-1:0]    wr_idx;
	logic [CW-1:0]     pick;

	assign wr_idx = RIW'(wr_slot);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_tab_q[wr_idx]  <= wr_addr;
			mask_tab_q[wr_idx]  <= wr_mask;
			class_tab_q[wr_idx] <= CW'(wr_class);
		end
	end

	always_comb begin
		for (int n = 0; n < RULES; n++) begin
			hit_now[n] = ((pkt_addr & mask_tab_q[n]) == addr_tab_q[n])
				&& (n < 32'(rule_count));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= '0;
		end else if (cmp_en) begin
			hit_s1 <= hit_now;
		end
	end

	always_comb begin
		pick = '0;
		for (int n = 0; n < RULES; n++) begin
			if (hit_s1[n]) begin
				pick = class_tab_q[n];
			end
		end
	end

	assign hit_class = (32'(pick) < CLASSES) ? pick : '0;

endmodule

// File: rtl/tca_counters.sv
// Counter memory of the traffic class accounting engine: byte and packet counts per class
// and direction, one synchronous memory with registered read and per-entry valid bits.
// Depends on tca_pkg.
module tca_counters #(
	parameter int CLASSES = tca_pkg::DEF_CLASSES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tca_pkg::cnt_ctrl_t                ctrl,
	input  logic [$clog2(2*CLASSES)-1:0]      rd_idx,
	input  logic [$clog2(2*CLASSES)-1:0]      wr_idx,
	input  logic [tca_pkg::BYTE_W-1:0]        wr_bytes,
	input  logic [tca_pkg::PKT_W-1:0]         wr_pkts,
	output logic [tca_pkg::BYTE_W-1:0]        rd_bytes,
	output logic [tca_pkg::PKT_W-1:0]         rd_pkts
);
	import tca_pkg::*;

	localparam int DEPTH = 2 * CLASSES;

	logic [BYTE_W+PKT_W-1:0] mem [DEPTH];
	logic [BYTE_W+PKT_W-1:0] rd_data_q;
	logic [DEPTH-1:0]        valid_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem[wr_idx] <= {wr_bytes, wr_pkts};
		end
		if (ctrl.rd) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// An entry not written since reset or the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				valid_q <= '0;
			end else if (ctrl.wr) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctrl.rd) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	assign rd_bytes = rd_valid_q ? rd_data_q[BYTE_W+PKT_W-1:PKT_W] : '0;
	assign rd_pkts  = rd_valid_q ? rd_data_q[PKT_W-1:0] : '0;

endmodule

// File: rtl/traffic_class_accounting.sv
// Top level of the traffic class accounting engine: command decode, configuration
// registers, counter update and result register. Depends on tca_pkg, tca_rules, tca_counters.
//
// Channel   Direction  Handshake            Payload
// command   in         start, busy          opcode slot match_addr match_mask class_sel
//                                           pkt_addr direction size
// config    in         cfg_valid, cfg_ready cfg_index cfg_data
// result    out        done (strobe)        status matched_class mark byte_count packet_count
//
// Every item is accepted with busy low, passes the s1 and s2 registers, and its result
// strobes on done from the result register. busy is high for one cycle after an accept,
// and no item is accepted while busy is high. A counter read-modify-write must finish
// before the next item reads the counter memory, which is why busy is raised.
// Reset makes all counters read as zero and clears the configuration registers; the rule
// table is undefined until loaded. Results cannot be held off by the receiver.
module traffic_class_accounting #(
	parameter int RULES   = tca_pkg::DEF_RULES,
	parameter int CLASSES = tca_pkg::DEF_CLASSES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [tca_pkg::OPCODE_W-1:0]          opcode,
	input  logic [tca_pkg::SLOT_W-1:0]            slot,
	input  logic [tca_pkg::ADDR_W-1:0]            match_addr,
	input  logic [tca_pkg::ADDR_W-1:0]            match_mask,
	input  logic [tca_pkg::CSEL_W-1:0]            class_sel,
	input  logic [tca_pkg::ADDR_W-1:0]            pkt_addr,
	input  logic                                  direction,
	input  logic signed [tca_pkg::SIZE_W-1:0]     size,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tca_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [tca_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                  done,
	output logic                                  status,
	output logic [tca_pkg::CLASS_OUT_W-1:0]       matched_class,
	output logic [tca_pkg::MARK_W-1:0]            mark,
	output logic [tca_pkg::BYTE_W-1:0]            byte_count,
	output logic [tca_pkg::PKT_W-1:0]             packet_count
);
	import tca_pkg::*;

	localparam int CW = $clog2(CLASSES);
	localparam int IW = $clog2(2 * CLASSES);
	localparam logic [MARK_W-1:0] MARK_STEP_CID  = MARK_W'(2 * CLASSES);
	localparam logic [MARK_W-1:0] MARK_STEP_BASE = MARK_W'(CLASSES);

	logic                      accept;
	logic                      csel_bad;
	logic                      rule_wr;
	logic [CW-1:0]             hit_class;

	logic [RULE_COUNT_W-1:0]   rule_count_q;
	logic [MARK_BASE_W-1:0]    mark_base_q;
	logic [CID_W-1:0]          container_id_q;

	logic                      s1_q;
	logic [OPCODE_W-1:0]       op_s1;
	logic                      dir_s1;
	logic signed [SIZE_W-1:0]  size_s1;
	logic [CW-1:0]             csel_s1;
	logic                      bad_s1;

	logic                      s2_q;
	logic [OPCODE_W-1:0]       op_s2;
	logic                      dir_s2;
	logic signed [SIZE_W-1:0]  size_s2;
	logic [CW-1:0]             cls_s2;
	logic                      bad_s2;
	logic [IW-1:0]             idx_s2;
	logic [MARK_W-1:0]         mark_mul_s2;

	logic [CW-1:0]             cls_s1;
	logic [IW-1:0]             idx_s1;
	logic [MARK_W-1:0]         mark_mul;
	cnt_ctrl_t                 cnt_ctrl;
	logic [BYTE_W-1:0]         rd_bytes;
	logic [PKT_W-1:0]          rd_pkts;
	logic [BYTE_W-1:0]         new_bytes;
	logic [PKT_W-1:0]          new_pkts;
	logic                      size_pos;

	logic                      done_q;
	logic                      status_q;
	logic [CLASS_OUT_W-1:0]    class_q;
	logic [MARK_W-1:0]         mark_q;
	logic [BYTE_W-1:0]         bytes_q;
	logic [PKT_W-1:0]          pkts_q;

	assign busy      = s1_q;
	assign accept    = start && !s1_q;
	assign cfg_ready = 1'b1;
	assign csel_bad  = !(32'(class_sel) < CLASSES);
	assign rule_wr   = accept && (opcode == OP_LOAD) && !csel_bad && (32'(slot) < RULES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q   <= '0;
			mark_base_q    <= '0;
			container_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RULE_COUNT:   rule_count_q   <= cfg_data[RULE_COUNT_W-1:0];
				CFG_MARK_BASE:    mark_base_q    <= cfg_data[MARK_BASE_W-1:0];
				CFG_CONTAINER_ID: container_id_q <= cfg_data[CID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tca_rules #(
		.RULES   (RULES),
		.CLASSES (CLASSES)
	) u_rules (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (rule_wr),
		.wr_slot    (slot),
		.wr_addr    (match_addr),
		.wr_mask    (match_mask),
		.wr_class   (class_sel),
		.cmp_en     (accept),
		.pkt_addr   (pkt_addr),
		.rule_count (rule_count_q),
		.hit_class  (hit_class)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= 1'b0;
			s2_q <= 1'b0;
		end else begin
			s1_q <= accept;
			s2_q <= s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			dir_s1  <= direction;
			size_s1 <= size;
			csel_s1 <= CW'(class_sel);
			bad_s1  <= csel_bad;
		end
	end

	assign cls_s1   = (op_s1 == OP_ACCOUNT) ? hit_class : csel_s1;
	assign idx_s1   = {cls_s1, dir_s1};
	assign mark_mul = (mark_base_q == '0) ? container_id_q * MARK_STEP_CID
		: MARK_W'(mark_base_q) * MARK_STEP_BASE;

	always_ff @(posedge clk) begin
		if (s1_q) begin
			op_s2       <= op_s1;
			dir_s2      <= dir_s1;
			size_s2     <= size_s1;
			cls_s2      <= cls_s1;
			bad_s2      <= bad_s1;
			idx_s2      <= idx_s1;
			mark_mul_s2 <= mark_mul;
		end
	end

	always_comb begin
		cnt_ctrl.rd  = s1_q && ((op_s1 == OP_ACCOUNT) || ((op_s1 == OP_READ) && !bad_s1));
		cnt_ctrl.wr  = s2_q && (op_s2 == OP_ACCOUNT);
		cnt_ctrl.clr = s2_q && (op_s2 == OP_CLEAR);
	end

	tca_counters #(
		.CLASSES (CLASSES)
	) u_counters (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (cnt_ctrl),
		.rd_idx   (idx_s1),
		.wr_idx   (idx_s2),
		.wr_bytes (new_bytes),
		.wr_pkts  (new_pkts),
		.rd_bytes (rd_bytes),
		.rd_pkts  (rd_pkts)
	);

	assign size_pos  = !size_s2[SIZE_W-1] && (size_s2 != '0);
	assign new_bytes = rd_bytes + BYTE_W'(size_s2);
	assign new_pkts  = size_pos ? rd_pkts + PKT_W'(1) : rd_pkts - PKT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_q) begin
			status_q <= 1'b0;
			class_q  <= '0;
			mark_q   <= '0;
			bytes_q  <= '0;
			pkts_q   <= '0;
			case (op_s2)
				OP_LOAD: begin
					status_q <= bad_s2;
				end
				OP_ACCOUNT: begin
					class_q <= CLASS_OUT_W'(cls_s2);
					mark_q  <= dir_s2 ? mark_mul_s2 + MARK_W'(cls_s2) : '0;
					bytes_q <= new_bytes;
					pkts_q  <= new_pkts;
				end
				OP_READ: begin
					status_q <= bad_s2;
					if (!bad_s2) begin
						bytes_q <= rd_bytes;
						pkts_q  <= rd_pkts;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign matched_class = class_q;
	assign mark          = mark_q;
	assign byte_count    = bytes_q;
	assign packet_count  = pkts_q;

endmodule

// File: rtl/tca_checker.sv
// Port-level checker for the traffic class accounting engine and its bind to the top level.
// Depends on tca_pkg and traffic_class_accounting.
module tca_port_checks (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic                                 status,
	input logic [tca_pkg::CLASS_OUT_W-1:0]      matched_class,
	input logic [tca_pkg::MARK_W-1:0]           mark,
	input logic [tca_pkg::BYTE_W-1:0]           byte_count,
	input logic [tca_pkg::PKT_W-1:0]            packet_count
);
	import tca_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("accepted item produced no result three cycles later");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result strobe without a matching accepted item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> (matched_class == '0) && (mark == '0)
			&& (byte_count == '0) && (packet_count == '0))
		else $error("rejected item returned nonzero fields");

endmodule

bind traffic_class_accounting tca_port_checks u_tca_checker (.*);

// File: tb/tca_checker.sv
`timescale 1ns / 1ps
// Checker for the traffic class accounting engine: follows rule loads, counters and
// register writes seen on the ports and compares every result with its own prediction.
// Depends on tca_pkg.
module tca_checker #(
	parameter int RULES   = tca_pkg::DEF_RULES,
	parameter int CLASSES = tca_pkg::DEF_CLASSES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [tca_pkg::OPCODE_W-1:0]      opcode,
	input  logic [tca_pkg::SLOT_W-1:0]        slot,
	input  logic [tca_pkg::ADDR_W-1:0]        match_addr,
	input  logic [tca_pkg::ADDR_W-1:0]        match_mask,
	input  logic [tca_pkg::CSEL_W-1:0]        class_sel,
	input  logic [tca_pkg::ADDR_W-1:0]        pkt_addr,
	input  logic                              direction,
	input  logic signed [tca_pkg::SIZE_W-1:0] size,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [tca_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tca_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              done,
	input  logic                              status,
	input  logic [tca_pkg::CLASS_OUT_W-1:0]   matched_class,
	input  logic [tca_pkg::MARK_W-1:0]        mark,
	input  logic [tca_pkg::BYTE_W-1:0]        byte_count,
	input  logic [tca_pkg::PKT_W-1:0]         packet_count,
	output int                                fails,
	output int                                due,
	output int                                checked
);
	import tca_pkg::*;

	typedef struct packed {
		logic                   status;
		logic [CLASS_OUT_W-1:0] cls;
		logic [MARK_W-1:0]      mark;
		logic [BYTE_W-1:0]      bytes;
		logic [PKT_W-1:0]       pkts;
	} tally_t;

	tally_t tallies_due[$];
	tally_t seen;
	tally_t want;

	logic [ADDR_W-1:0] rule_addr [0:RULES-1];
	logic [ADDR_W-1:0] rule_mask [0:RULES-1];
	int unsigned       rule_cls  [0:RULES-1];
	logic [BYTE_W-1:0] byte_tab  [0:2*CLASSES-1];
	logic [PKT_W-1:0]  pkt_tab   [0:2*CLASSES-1];

	int unsigned            n_rules;
	logic [MARK_BASE_W-1:0] mark_base;
	logic [CID_W-1:0]       cid;

	initial begin
		fails = 0;
		due = 0;
		checked = 0;
	end

	function automatic tally_t tally_for(
		input logic [OPCODE_W-1:0] op,
		input logic [SLOT_W-1:0]   sl,
		input logic [ADDR_W-1:0]   ma,
		input logic [ADDR_W-1:0]   mm,
		input logic [CSEL_W-1:0]   cs,
		input logic [ADDR_W-1:0]   pa,
		input logic                dir,
		input logic [SIZE_W-1:0]   sz
	);
		tally_t t;
		int unsigned cls;
		int unsigned idx;
		int unsigned lim;
		logic found;
		logic [BYTE_W-1:0] delta;
		t = '0;
		case (op)
		OP_LOAD: begin
			if (cs >= CLASSES) begin
				t.status = 1'b1;
			end else if (sl < RULES) begin
				rule_addr[sl] = ma;
				rule_mask[sl] = mm;
				rule_cls[sl] = 32'(cs);
			end
		end
		OP_ACCOUNT: begin
			cls = 0;
			found = 1'b0;
			lim = (n_rules > RULES) ? RULES : n_rules;
			for (int i = RULES - 1; i >= 0; i--) begin
				if (!found && i < lim && (pa & rule_mask[i]) == rule_addr[i]) begin
					cls = rule_cls[i];
					found = 1'b1;
				end
			end
			if (cls >= CLASSES)
				cls = 0;
			idx = cls * 2 + dir;
			delta = {{(BYTE_W-SIZE_W){sz[SIZE_W-1]}}, sz};
			byte_tab[idx] = byte_tab[idx] + delta;
			if (!sz[SIZE_W-1] && sz != '0)
				pkt_tab[idx] = pkt_tab[idx] + 1'b1;
			else
				pkt_tab[idx] = pkt_tab[idx] - 1'b1;
			t.cls = cls[CLASS_OUT_W-1:0];
			t.bytes = byte_tab[idx];
			t.pkts = pkt_tab[idx];
			if (dir) begin
				if (mark_base == '0)
					t.mark = MARK_W'(cls) + cid * MARK_W'(2 * CLASSES);
				else
					t.mark = MARK_W'(cls) + MARK_W'(mark_base) * MARK_W'(CLASSES);
			end
		end
		OP_READ: begin
			if (cs >= CLASSES) begin
				t.status = 1'b1;
			end else begin
				idx = cs * 2 + dir;
				t.bytes = byte_tab[idx];
				t.pkts = pkt_tab[idx];
			end
		end
		default: begin
			for (int i = 0; i < 2 * CLASSES; i++) begin
				byte_tab[i] = '0;
				pkt_tab[i] = '0;
			end
		end
		endcase
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RULES; i++) begin
				rule_addr[i] = '0;
				rule_mask[i] = '0;
				rule_cls[i] = 0;
			end
			for (int i = 0; i < 2 * CLASSES; i++) begin
				byte_tab[i] = '0;
				pkt_tab[i] = '0;
			end
			n_rules = 0;
			mark_base = '0;
			cid = '0;
			tallies_due.delete();
			due = 0;
		end else begin
			if (done) begin
				seen = {status, matched_class, mark, byte_count, packet_count};
				if (tallies_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result with no item outstanding: status %0d class %0d",
							$realtime, seen.status, seen.cls);
				end else begin
					want = tallies_due.pop_front();
					checked++;
					if (seen.status !== want.status || seen.cls !== want.cls ||
							seen.mark !== want.mark || seen.bytes !== want.bytes ||
							seen.pkts !== want.pkts) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: mismatch, wanted status %0d class %0d mark %h",
								" bytes %h pkts %h, got %0d %0d %h %h %h"}, $realtime,
								want.status, want.cls, want.mark, want.bytes, want.pkts,
								seen.status, seen.cls, seen.mark, seen.bytes, seen.pkts);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_RULE_COUNT:   n_rules = 32'(cfg_data[RULE_COUNT_W-1:0]);
				CFG_MARK_BASE:    mark_base = cfg_data[MARK_BASE_W-1:0];
				CFG_CONTAINER_ID: cid = cfg_data[CID_W-1:0];
				default: ;
				endcase
			end
			if (start && !busy)
				tallies_due.push_back(tally_for(opcode, slot, match_addr, match_mask,
					class_sel, pkt_addr, direction, size));
			due = tallies_due.size();
		end
	end

endmodule

// File: tb/tb_traffic_class_accounting.sv
`timescale 1ns / 1ps
// Top of the traffic class accounting testbench: clock, reset, command and register
// stimulus, and the verdict. Depends on tca_pkg, traffic_class_accounting and tca_checker.
module tb_traffic_class_accounting;
	import tca_pkg::*;

	localparam int RULES       = DEF_RULES;
	localparam int CLASSES     = DEF_CLASSES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 100;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [OPCODE_W-1:0]       opcode = OP_LOAD;
	logic [SLOT_W-1:0]         slot = '0;
	logic [ADDR_W-1:0]         match_addr = '0;
	logic [ADDR_W-1:0]         match_mask = '0;
	logic [CSEL_W-1:0]         class_sel = '0;
	logic [ADDR_W-1:0]         pkt_addr = '0;
	logic                      direction = 1'b0;
	logic signed [SIZE_W-1:0]  size = '0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_W-1:0]    cfg_index = CFG_RULE_COUNT;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      done;
	logic                      status;
	logic [CLASS_OUT_W-1:0]    matched_class;
	logic [MARK_W-1:0]         mark;
	logic [BYTE_W-1:0]         byte_count;
	logic [PKT_W-1:0]          packet_count;

	int fails;
	int due;
	int checked;
	int cycles = 0;
	int n_ops [4] = '{0, 0, 0, 0};
	int n_settings = 0;
	logic gaps_on = 1'b1;

	logic [ADDR_W-1:0] known_addr [0:RULES-1];
	logic [ADDR_W-1:0] known_mask [0:RULES-1];

	traffic_class_accounting dut (.*);

	tca_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_traffic_class_accounting: errors");
			$finish;
		end
	end

	task automatic send_cmd(
		input logic [OPCODE_W-1:0] op,
		input logic [SLOT_W-1:0]   sl,
		input logic [ADDR_W-1:0]   ma,
		input logic [ADDR_W-1:0]   mm,
		input logic [CSEL_W-1:0]   cs,
		input logic [ADDR_W-1:0]   pa,
		input logic                dir,
		input logic [SIZE_W-1:0]   sz
	);
		int gap;
		gap = (gaps_on && $urandom_range(99) < 38) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		slot <= sl;
		match_addr <= ma;
		match_mask <= mm;
		class_sel <= cs;
		pkt_addr <= pa;
		direction <= dir;
		size <= sz;
		do @(posedge clk); while (busy);
		n_ops[op]++;
		if (op == OP_LOAD && cs < CLASSES) begin
			known_addr[sl] = ma;
			known_mask[sl] = mm;
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned rc, input logic [MARK_BASE_W-1:0] mb,
			input logic [CID_W-1:0] cid);
		write_reg(CFG_RULE_COUNT, ($urandom & ~32'h1F) | rc);
		write_reg(CFG_MARK_BASE, ($urandom & ~32'hFFFF) | mb);
		write_reg(CFG_CONTAINER_ID, cid);
		write_reg(2'd3, $urandom);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] prefix_mask();
		int len;
		len = $urandom_range(0, 32);
		return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (32 - len));
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		int s;
		s = $urandom_range(RULES - 1);
		case ($urandom_range(9))
		0, 1, 2, 3, 4, 5: return (known_addr[s] & known_mask[s]) | ($urandom & ~known_mask[s]);
		6: return '0;
		7: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
		0: return '0;
		1: return 17'h0FFFF;
		2: return 17'h10000;
		3: return '1;
		4, 5: return SIZE_W'($urandom_range(1, 1500));
		6: return -SIZE_W'($urandom_range(1, 1500));
		default: return SIZE_W'($urandom);
		endcase
	endfunction

	task automatic random_cmd();
		int r;
		logic [ADDR_W-1:0] mm;
		logic [ADDR_W-1:0] ma;
		logic [CSEL_W-1:0] cs;
		r = $urandom_range(99);
		mm = ($urandom_range(9) < 8) ? prefix_mask() : $urandom;
		ma = ($urandom_range(9) < 7) ? ($urandom & mm) : $urandom;
		if (r < 14) begin
			cs = ($urandom_range(99) < 85) ? CSEL_W'($urandom_range(CLASSES - 1))
				: CSEL_W'($urandom_range(CLASSES, 255));
			send_cmd(OP_LOAD, SLOT_W'($urandom), ma, mm, cs, $urandom, 1'($urandom),
				SIZE_W'($urandom));
		end else if (r < 74) begin
			send_cmd(OP_ACCOUNT, SLOT_W'($urandom), ma, mm, CSEL_W'($urandom), pick_addr(),
				1'($urandom), pick_size());
		end else if (r < 96) begin
			cs = ($urandom_range(99) < 90) ? CSEL_W'($urandom_range(CLASSES - 1))
				: CSEL_W'($urandom);
			send_cmd(OP_READ, SLOT_W'($urandom), ma, mm, cs, $urandom, 1'($urandom),
				SIZE_W'($urandom));
		end else begin
			send_cmd(OP_CLEAR, SLOT_W'($urandom), ma, mm, CSEL_W'($urandom), $urandom,
				1'($urandom), SIZE_W'($urandom));
		end
	endtask

	int unsigned       phase_rc  [PHASES];
	logic [15:0]       phase_mb  [PHASES];
	logic [CID_W-1:0]  phase_cid [PHASES];

	initial begin
		logic [ADDR_W-1:0] mm;
		phase_rc = '{31, 0, 16, $urandom_range(1, 16), $urandom_range(0, 31)};
		phase_mb = '{16'hFFFF, 16'h0, 16'($urandom), 16'h0, 16'($urandom)};
		phase_cid = '{$urandom, 32'h0, $urandom, $urandom, 32'hFFFFFFFF};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill every slot with no rule in use, so later rule counts never reach an
		// empty slot. The two ends hold exact matches on all ones and all zeros.
		send_cmd(OP_LOAD, 4'd0, '1, '1, 8'd15, $urandom, 1'($urandom), SIZE_W'($urandom));
		for (int s = 1; s < RULES - 1; s++) begin
			mm = prefix_mask();
			send_cmd(OP_LOAD, SLOT_W'(s), $urandom & mm, mm, CSEL_W'(s), $urandom,
				1'($urandom), SIZE_W'($urandom));
		end
		send_cmd(OP_LOAD, 4'd15, '0, '1, 8'd0, $urandom, 1'($urandom), SIZE_W'($urandom));
		send_cmd(OP_ACCOUNT, '0, '0, '0, '0, $urandom, 1'b1, 17'h0FFFF);
		send_cmd(OP_LOAD, 4'd3, '1, '1, CSEL_W'(CLASSES), '0, 1'b0, '0);
		send_cmd(OP_LOAD, 4'd4, '0, '0, 8'hFF, '0, 1'b0, '0);
		send_cmd(OP_READ, '0, '0, '0, CSEL_W'(CLASSES), '0, 1'b0, '0);
		send_cmd(OP_READ, '0, '0, '0, 8'hFF, '0, 1'b1, '0);

		wait_idle();
		configure(16, 16'h0, 32'hFFFFFFFF);
		send_cmd(OP_ACCOUNT, '0, '0, '0, '0, '1, 1'b1, 17'h10000);
		send_cmd(OP_ACCOUNT, '0, '0, '0, '0, '0, 1'b0, '0);
		send_cmd(OP_ACCOUNT, '0, '0, '0, '0, '1, 1'b0, 17'h0FFFF);
		send_cmd(OP_READ, '0, '0, '0, 8'd15, '0, 1'b1, '0);
		send_cmd(OP_READ, '0, '0, '0, 8'd0, '0, 1'b0, '0);
		send_cmd(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0, '0);
		send_cmd(OP_READ, '0, '0, '0, 8'd15, '0, 1'b1, '0);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			configure(phase_rc[p], phase_mb[p], phase_cid[p]);
			gaps_on = (p != 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				random_cmd();
		end
		gaps_on = 1'b1;

		start <= 1'b0;
		while (due != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("Sent %0d loads, %0d packets, %0d reads and %0d clears under %0d settings.",
			n_ops[OP_LOAD], n_ops[OP_ACCOUNT], n_ops[OP_READ], n_ops[OP_CLEAR], n_settings);
		$display("Checked %0d results, %0d failures.", checked, fails);
		if (fails == 0)
			$display("tb_traffic_class_accounting: clean");
		else
			$display("tb_traffic_class_accounting: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/tca_pkg.sv
rtl/tca_rules.sv
rtl/tca_counters.sv
rtl/traffic_class_accounting.sv
rtl/tca_checker.sv
tb/tca_checker.sv
tb/tb_traffic_class_accounting.sv
